FILE: rtl/core/i2cm_pkg.sv
package i2cm_pkg;

    // Configuration register map
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [1:0] REG_START_HOLD = 2'd0;
    localparam logic [1:0] REG_HALF_BIT   = 2'd1;
    localparam logic [1:0] REG_ACK_TMO    = 2'd2;

    localparam logic [7:0] RST_START_HOLD = 8'd4;
    localparam logic [7:0] RST_HALF_BIT   = 8'd1;
    localparam logic [7:0] RST_ACK_TMO    = 8'd250;

    // Input item actions
    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_BEGIN_WR  = 3'd1;
    localparam logic [2:0] ACT_BEGIN_RD  = 3'd2;
    localparam logic [2:0] ACT_WR_BYTE   = 3'd3;
    localparam logic [2:0] ACT_WR_BIT    = 3'd4;

    typedef struct packed {
        logic [7:0] start_hold_ticks;
        logic [7:0] half_bit_ticks;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic       sda_in;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic [2:0] bit_number;
        logic       bit_value;
    } in_item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_release;
        logic       read_valid;
        logic [7:0] read_data;
        logic       last_read;
        logic       write_data_request;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
    } out_item_t;

endpackage

FILE: rtl/core/i2c_master_register_access_top.sv
// I2C master register-access sequencer.
// Input channel (in_valid/in_stall/in_data): each transfer is one tick of
// bus time or one command (begin write, begin read, supply write byte,
// write bit). Output channel (out_valid/out_stall/out_data): exactly one
// result per input transfer, carrying the SCL/SDA levels to drive, a
// received byte with its last mark, the write data request, and
// busy/done/ack error status.
// The result of an input transfer is registered and appears on out_data in the cycle after the transfer.
// Throughput: one item per cycle while in_stall is low; the sequencer state update and the
// result both come from a single combinational pass between the state
// registers and the output register.
// The output register frees in the cycle it is taken, so a new input is
// accepted while a result is being drained. When the receiver stalls with
// a result held, in_stall rises and the held result does not change.
// Timing registers are written over the APB-style port at byte addresses
// 0 (start hold ticks), 4 (half bit ticks) and 8 (ack timeout).
// Reset puts the sequencer idle (lines high, driven), clears all status
// and loads the timing registers with 4, 1 and 250.
module i2c_master_register_access_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  i2cm_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output i2cm_pkg::out_item_t             out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [i2cm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import i2cm_pkg::*;

    cfg_t      cfg;
    out_item_t res;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    logic      accept;

    i2cm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stall input only while a result is held and the receiver stalls
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    i2cm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cfg    (cfg),
        .res    (res)
    );

    // Load the result register on each transfer; drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/core/i2cm_cfg.sv
module i2cm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [i2cm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output i2cm_pkg::cfg_t                 cfg
);
    import i2cm_pkg::*;

    logic [7:0] start_hold_reg;
    logic [7:0] half_bit_reg;
    logic [7:0] ack_tmo_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Write the addressed register; ignore addresses past the map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_hold_reg <= RST_START_HOLD;
            half_bit_reg   <= RST_HALF_BIT;
            ack_tmo_reg    <= RST_ACK_TMO;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_START_HOLD: start_hold_reg <= pwdata[7:0];
                REG_HALF_BIT:   half_bit_reg   <= pwdata[7:0];
                REG_ACK_TMO:    ack_tmo_reg    <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // Return the addressed register on a read
    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_START_HOLD: prdata[7:0] = start_hold_reg;
            REG_HALF_BIT:   prdata[7:0] = half_bit_reg;
            REG_ACK_TMO:    prdata[7:0] = ack_tmo_reg;
            default:        prdata = '0;
        endcase
    end

    assign cfg.start_hold_ticks = start_hold_reg;
    assign cfg.half_bit_ticks   = half_bit_reg;
    assign cfg.ack_timeout      = ack_tmo_reg;

endmodule

FILE: rtl/core/i2cm_seq.sv
module i2cm_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  i2cm_pkg::in_item_t  item,
    input  i2cm_pkg::cfg_t      cfg,
    output i2cm_pkg::out_item_t res
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_STA_HI    = 5'd1,
        PH_STA_LO    = 5'd2,
        PH_TX_LO     = 5'd3,
        PH_TX_HI     = 5'd4,
        PH_ACK_LO    = 5'd5,
        PH_ACK_HI    = 5'd6,
        PH_ACK_POLL  = 5'd7,
        PH_WAIT_DATA = 5'd8,
        PH_RX_LO     = 5'd9,
        PH_RX_HI     = 5'd10,
        PH_MACK_LO   = 5'd11,
        PH_MACK_HI   = 5'd12,
        PH_RS_SETUP  = 5'd13,
        PH_STO_A     = 5'd14,
        PH_STO_B     = 5'd15,
        PH_STO_C     = 5'd16
    } phase_t;

    typedef enum logic [1:0] {
        STG_DEVW = 2'd0,
        STG_REG  = 2'd1,
        STG_DEVR = 2'd2,
        STG_DATA = 2'd3
    } stage_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic rel;
    } line_t;

    // Bus line levels for a phase
    function automatic line_t phase_lines(phase_t p, logic shift_msb, logic last_byte);
        line_t l;
        l.scl = 1'b1;
        l.sda = 1'b1;
        l.rel = 1'b0;
        case (p)
            PH_STA_LO:   l.sda = 1'b0;
            PH_TX_LO:
            begin
                l.scl = 1'b0;
                l.sda = shift_msb;
            end
            PH_TX_HI:    l.sda = shift_msb;
            PH_ACK_LO, PH_WAIT_DATA, PH_RX_LO:
            begin
                l.scl = 1'b0;
                l.sda = 1'b0;
                l.rel = 1'b1;
            end
            PH_ACK_HI, PH_ACK_POLL, PH_RX_HI:
            begin
                l.sda = 1'b0;
                l.rel = 1'b1;
            end
            PH_MACK_LO:
            begin
                l.scl = 1'b0;
                l.sda = last_byte;
            end
            PH_MACK_HI:  l.sda = last_byte;
            PH_RS_SETUP: l.scl = 1'b0;
            PH_STO_A:
            begin
                l.scl = 1'b0;
                l.sda = 1'b0;
            end
            PH_STO_B:    l.sda = 1'b0;
            default:     ;
        endcase
        return l;
    endfunction

    phase_t     phase_reg,      phase_next;
    stage_t     stage_reg,      stage_next;
    logic [7:0] tick_cnt_reg,   tick_cnt_next;
    logic [3:0] bit_cnt_reg,    bit_cnt_next;
    logic [7:0] shift_reg,      shift_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] ack_polls_reg,  ack_polls_next;
    logic [7:0] held_dev_reg,   held_dev_next;
    logic [7:0] held_regad_reg, held_regad_next;
    logic [3:0] held_bit_reg,   held_bit_next;
    logic [8:0] pending_reg,    pending_next;
    logic       error_reg,      error_next;
    logic       rd_flag_reg,    rd_flag_next;
    logic       mod_flag_reg,   mod_flag_next;

    logic       cmd;
    logic       rd_valid;
    logic       rd_last;
    logic       fin;
    logic [7:0] rd_byte;
    logic [7:0] hold_len;
    logic [7:0] half_len;
    logic [7:0] seg_len;
    logic       seg_more;
    logic [7:0] rx_byte;
    logic [7:0] bit_mask;
    logic [7:0] mod_byte;
    logic [3:0] bit_cnt_inc;
    logic       busy_before;
    line_t      cur_lines;
    line_t      new_lines;

    // Segment length of the current phase; zero acts as one
    assign hold_len = (cfg.start_hold_ticks == 8'd0) ? 8'd1 : cfg.start_hold_ticks;
    assign half_len = (cfg.half_bit_ticks == 8'd0) ? 8'd1 : cfg.half_bit_ticks;
    always_comb
    begin
        case (phase_reg)
            PH_STA_HI, PH_STA_LO, PH_RS_SETUP, PH_STO_A, PH_STO_B, PH_STO_C:
                seg_len = hold_len;
            default:
                seg_len = half_len;
        endcase
    end
    assign seg_more    = ({1'b0, tick_cnt_reg} + 9'd1) < {1'b0, seg_len};
    assign bit_cnt_inc = bit_cnt_reg + 4'd1;
    assign rx_byte     = {shift_reg[6:0], item.sda_in};
    assign bit_mask    = 8'd1 << held_bit_reg[2:0];
    assign mod_byte    = held_bit_reg[3] ? (rx_byte | bit_mask) : (rx_byte & ~bit_mask);
    assign cmd         = (item.action == ACT_BEGIN_WR) || (item.action == ACT_BEGIN_RD) ||
                         (item.action == ACT_WR_BYTE)  || (item.action == ACT_WR_BIT);
    assign busy_before = phase_reg != PH_IDLE;

    // Advance the sequencer by one command or one tick
    always_comb
    begin
        phase_next      = phase_reg;
        stage_next      = stage_reg;
        tick_cnt_next   = tick_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        ack_polls_next  = ack_polls_reg;
        held_dev_next   = held_dev_reg;
        held_regad_next = held_regad_reg;
        held_bit_next   = held_bit_reg;
        pending_next    = pending_reg;
        error_next      = error_reg;
        rd_flag_next    = rd_flag_reg;
        mod_flag_next   = mod_flag_reg;
        rd_valid        = 1'b0;
        rd_last         = 1'b0;
        rd_byte         = 8'd0;
        fin             = 1'b0;

        if (cmd)
        begin
            if (item.action == ACT_WR_BYTE)
            begin
                // Take the data byte only while waiting for it
                if (phase_reg == PH_WAIT_DATA)
                begin
                    shift_next    = item.write_data;
                    bit_cnt_next  = 4'd0;
                    phase_next    = PH_TX_LO;
                    tick_cnt_next = 8'd0;
                end
            end
            else if (phase_reg == PH_IDLE)
            begin
                held_dev_next   = {item.device_address[7:1], 1'b0};
                held_regad_next = item.register_address;
                error_next      = 1'b0;
                pending_next    = 9'd0;
                stage_next      = STG_DEVW;
                ack_polls_next  = 8'd0;
                phase_next      = PH_STA_HI;
                tick_cnt_next   = 8'd0;
                if (item.action == ACT_WR_BIT)
                begin
                    held_bit_next   = {item.bit_value, item.bit_number};
                    rd_flag_next    = 1'b1;
                    mod_flag_next   = 1'b1;
                    bytes_left_next = 8'd1;
                end
                else
                begin
                    held_bit_next   = 4'd0;
                    rd_flag_next    = item.action == ACT_BEGIN_RD;
                    mod_flag_next   = 1'b0;
                    bytes_left_next = item.byte_count;
                end
            end
        end
        else if (phase_reg == PH_IDLE || phase_reg == PH_WAIT_DATA)
        begin
            // Hold: nothing advances
        end
        else if (phase_reg == PH_ACK_POLL)
        begin
            if (!item.sda_in)
            begin
                // Acknowledge seen: move to the next transaction stage
                tick_cnt_next = 8'd0;
                case (stage_reg)
                    STG_DEVW:
                    begin
                        stage_next   = STG_REG;
                        shift_next   = held_regad_reg;
                        bit_cnt_next = 4'd0;
                        phase_next   = PH_TX_LO;
                    end
                    STG_DEVR:
                    begin
                        stage_next = STG_DATA;
                        if (bytes_left_reg == 8'd0)
                            phase_next = PH_STO_A;
                        else
                        begin
                            shift_next   = 8'd0;
                            bit_cnt_next = 4'd0;
                            phase_next   = PH_RX_LO;
                        end
                    end
                    default:
                    begin
                        if (stage_reg == STG_REG && rd_flag_reg)
                        begin
                            stage_next = STG_DEVR;
                            phase_next = PH_RS_SETUP;
                        end
                        else
                        begin
                            stage_next = STG_DATA;
                            if (bytes_left_reg == 8'd0)
                                phase_next = PH_STO_A;
                            else
                            begin
                                bytes_left_next = bytes_left_reg - 8'd1;
                                if (pending_reg[8])
                                begin
                                    pending_next = 9'd0;
                                    shift_next   = pending_reg[7:0];
                                    bit_cnt_next = 4'd0;
                                    phase_next   = PH_TX_LO;
                                end
                                else
                                    phase_next = PH_WAIT_DATA;
                            end
                        end
                    end
                endcase
            end
            else if (ack_polls_reg >= cfg.ack_timeout)
            begin
                // Timed out: drop any pending write and stop
                error_next    = 1'b1;
                pending_next  = 9'd0;
                mod_flag_next = 1'b0;
                phase_next    = PH_STO_A;
                tick_cnt_next = 8'd0;
            end
            else
                ack_polls_next = ack_polls_reg + 8'd1;
        end
        else if (seg_more)
            tick_cnt_next = tick_cnt_reg + 8'd1;
        else
        begin
            // End of segment
            tick_cnt_next = 8'd0;
            case (phase_reg)
                PH_STA_HI: phase_next = PH_STA_LO;
                PH_STA_LO:
                begin
                    shift_next   = (stage_reg == STG_DEVR) ? (held_dev_reg | 8'd1)
                                                           : held_dev_reg;
                    bit_cnt_next = 4'd0;
                    phase_next   = PH_TX_LO;
                end
                PH_TX_LO: phase_next = PH_TX_HI;
                PH_TX_HI:
                begin
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_cnt_next = bit_cnt_inc;
                    phase_next   = (bit_cnt_inc >= 4'd8) ? PH_ACK_LO : PH_TX_LO;
                end
                PH_ACK_LO: phase_next = PH_ACK_HI;
                PH_ACK_HI:
                begin
                    ack_polls_next = 8'd0;
                    phase_next     = PH_ACK_POLL;
                end
                PH_RX_LO: phase_next = PH_RX_HI;
                PH_RX_HI:
                begin
                    shift_next   = rx_byte;
                    bit_cnt_next = bit_cnt_inc;
                    if (bit_cnt_inc < 4'd8)
                        phase_next = PH_RX_LO;
                    else
                    begin
                        if (mod_flag_reg)
                            pending_next = {1'b1, mod_byte};
                        else
                        begin
                            rd_valid = 1'b1;
                            rd_byte  = rx_byte;
                            rd_last  = bytes_left_reg == 8'd1;
                        end
                        if (bytes_left_reg != 8'd0)
                            bytes_left_next = bytes_left_reg - 8'd1;
                        phase_next = PH_MACK_LO;
                    end
                end
                PH_MACK_LO: phase_next = PH_MACK_HI;
                PH_MACK_HI:
                begin
                    if (bytes_left_reg == 8'd0)
                        phase_next = PH_STO_A;
                    else
                    begin
                        shift_next   = 8'd0;
                        bit_cnt_next = 4'd0;
                        phase_next   = PH_RX_LO;
                    end
                end
                PH_RS_SETUP: phase_next = PH_STA_HI;
                PH_STO_A:    phase_next = PH_STO_B;
                PH_STO_B:    phase_next = PH_STO_C;
                PH_STO_C:
                begin
                    if (pending_reg[8] && !error_reg)
                    begin
                        // Write back the modified byte in a second transaction
                        rd_flag_next    = 1'b0;
                        mod_flag_next   = 1'b0;
                        bytes_left_next = 8'd1;
                        stage_next      = STG_DEVW;
                        ack_polls_next  = 8'd0;
                        phase_next      = PH_STA_HI;
                    end
                    else
                    begin
                        pending_next  = 9'd0;
                        mod_flag_next = 1'b0;
                        fin           = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Assemble the result for this transfer
    assign cur_lines = phase_lines(phase_reg, shift_reg[7], bytes_left_reg == 8'd0);
    assign new_lines = phase_lines(phase_next, shift_next[7], bytes_left_next == 8'd0);

    always_comb
    begin
        if (cmd)
        begin
            res.scl                = new_lines.scl;
            res.sda_out            = new_lines.sda;
            res.sda_release        = new_lines.rel;
            res.busy_res           = phase_next != PH_IDLE;
            res.write_data_request = phase_next == PH_WAIT_DATA;
        end
        else
        begin
            res.scl                = cur_lines.scl;
            res.sda_out            = cur_lines.sda;
            res.sda_release        = cur_lines.rel;
            res.busy_res           = busy_before;
            res.write_data_request = cur_lines.rel && !cur_lines.scl && busy_before &&
                                     (phase_next == PH_WAIT_DATA);
        end
        res.read_valid = rd_valid;
        res.read_data  = rd_byte;
        res.last_read  = rd_valid && rd_last;
        res.done_res   = fin;
        res.ack_error  = error_next;
    end

    // Hold sequencer state; update on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            stage_reg      <= STG_DEVW;
            tick_cnt_reg   <= 8'd0;
            bit_cnt_reg    <= 4'd0;
            shift_reg      <= 8'd0;
            bytes_left_reg <= 8'd0;
            ack_polls_reg  <= 8'd0;
            held_dev_reg   <= 8'd0;
            held_regad_reg <= 8'd0;
            held_bit_reg   <= 4'd0;
            pending_reg    <= 9'd0;
            error_reg      <= 1'b0;
            rd_flag_reg    <= 1'b0;
            mod_flag_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            stage_reg      <= stage_next;
            tick_cnt_reg   <= tick_cnt_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            ack_polls_reg  <= ack_polls_next;
            held_dev_reg   <= held_dev_next;
            held_regad_reg <= held_regad_next;
            held_bit_reg   <= held_bit_next;
            pending_reg    <= pending_next;
            error_reg      <= error_next;
            rd_flag_reg    <= rd_flag_next;
            mod_flag_reg   <= mod_flag_next;
        end
    end

`ifndef SYNTH
    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= 4'd8)
        else $error("bit counter past one byte");

    a_read_in_txn: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.read_valid |-> res.busy_res && !mod_flag_reg)
        else $error("read byte presented outside a plain read");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.done_res |=> phase_reg == PH_IDLE && pending_reg == 9'd0)
        else $error("done without returning to idle");

    a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.sda_release |-> !res.sda_out)
        else $error("SDA level driven while released");

    a_request_waits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.write_data_request |-> !res.scl && res.sda_release)
        else $error("data request while SCL not held low");
`endif

endmodule
